/* sv/b64d_pkg.sv */
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int SYMBOL_W = 8;
    localparam int SEXTET_W = 6;
    localparam int BYTE_W = 8;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_UNSET = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STANDARD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_URL_MIXED = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_STANDARD;

    localparam logic [SYMBOL_W-1:0] PAD_CHAR = 8'd61;
    localparam logic [SEXTET_W-1:0] SEXTET_PLUS = 6'd62;
    localparam logic [SEXTET_W-1:0] SEXTET_SLASH = 6'd63;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_PAD,
        KIND_BAD
    } sym_kind_t;

    typedef struct packed {
        sym_kind_t             kind;
        logic [SEXTET_W-1:0]   sextet;
        logic                  fin;
    } queue_entry_t;

    // Map one character to its class and 6-bit value under the given mode.
    // An unset or undefined mode marks every character bad.
    function automatic queue_entry_t classify(input logic [SYMBOL_W-1:0] c,
                                              input logic [MODE_W-1:0] mode,
                                              input logic fin);
        queue_entry_t e;
        logic mode_ok;
        logic url_ok;
        mode_ok = (mode == MODE_STANDARD) || (mode == MODE_URL_MIXED);
        url_ok = (mode == MODE_URL_MIXED);
        e.fin = fin;
        e.kind = KIND_BAD;
        e.sextet = '0;
        case (c) inside
            [8'd65:8'd90]:
            begin
                e.kind = KIND_DATA;
                e.sextet = SEXTET_W'(c - 8'd65);
            end
            [8'd97:8'd122]:
            begin
                e.kind = KIND_DATA;
                e.sextet = SEXTET_W'(c - 8'd71);
            end
            [8'd48:8'd57]:
            begin
                e.kind = KIND_DATA;
                e.sextet = SEXTET_W'(c + 8'd4);
            end
            8'd43:
            begin
                e.kind = KIND_DATA;
                e.sextet = SEXTET_PLUS;
            end
            8'd47:
            begin
                e.kind = KIND_DATA;
                e.sextet = SEXTET_SLASH;
            end
            8'd45:
            begin
                e.kind = url_ok ? KIND_DATA : KIND_BAD;
                e.sextet = SEXTET_PLUS;
            end
            8'd95:
            begin
                e.kind = url_ok ? KIND_DATA : KIND_BAD;
                e.sextet = SEXTET_SLASH;
            end
            PAD_CHAR:
            begin
                e.kind = KIND_PAD;
            end
            default:
            begin
                e.kind = KIND_BAD;
            end
        endcase
        if (!mode_ok)
        begin
            e.kind = KIND_BAD;
        end
        return e;
    endfunction

endpackage

/* sv/b64d_if.sv */
`timescale 1ns / 1ps

interface b64d_text_if;
    logic                          valid;
    logic                          ready;
    logic [b64d_pkg::SYMBOL_W-1:0] symbol;
    logic                          final_symbol;

    modport source (output valid, output symbol, output final_symbol, input ready);
    modport sink (input valid, input symbol, input final_symbol, output ready);
endinterface

interface b64d_byte_if;
    logic                        valid;
    logic                        ready;
    logic [b64d_pkg::BYTE_W-1:0] data_byte;
    logic                        byte_valid;
    logic                        end_of_text;
    logic                        failed;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_text, output failed, input ready);
    modport sink (input valid, input data_byte, input byte_valid,
                  input end_of_text, input failed, output ready);
endinterface

interface b64d_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [b64d_pkg::MODE_W-1:0] alphabet_mode;

    modport source (output valid, output alphabet_mode, input ready);
    modport sink (input valid, input alphabet_mode, output ready);
endinterface

/* sv/b64d_front.sv */
`timescale 1ns / 1ps

module b64d_front (
    input  logic                   clk,
    input  logic                   rst_n,
    b64d_cfg_if.sink               cfg,
    b64d_text_if.sink              text,
    output logic                   push,
    output b64d_pkg::queue_entry_t push_entry,
    input  logic                   queue_ready
);
    import b64d_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;

    assign cfg.ready = 1'b1;
    assign mode_next = (cfg.valid) ? cfg.alphabet_mode : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Classify on the way in; the queue carries only class, value and end mark.
    assign text.ready = queue_ready;
    assign push = text.valid && queue_ready;
    assign push_entry = classify(text.symbol, mode_reg, text.final_symbol);

endmodule

/* sv/b64d_queue.sv */
`timescale 1ns / 1ps

module b64d_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  b64d_pkg::queue_entry_t push_entry,
    output logic                   not_full,
    output logic                   not_empty,
    input  logic                   pop,
    output b64d_pkg::queue_entry_t head
);
    import b64d_pkg::*;

    queue_entry_t entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign not_full = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (not_full || pop && not_empty))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");
`endif

endmodule

/* sv/b64d_back.sv */
`timescale 1ns / 1ps

module b64d_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  b64d_pkg::queue_entry_t head,
    output logic                   pop,
    b64d_byte_if.source            decoded
);
    import b64d_pkg::*;

    logic [1:0]          pos_reg;
    logic [1:0]          pos_next;
    logic [SEXTET_W-1:0] prev_reg;
    logic [SEXTET_W-1:0] prev_next;
    logic                pad_reg;
    logic                pad_next;
    logic                err_reg;
    logic                err_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_bvalid_reg;
    logic                out_eot_reg;
    logic                out_failed_reg;

    logic                have_byte;
    logic [BYTE_W-1:0]   byte_val;
    logic                emit;
    logic                load;

    // Advance whenever the output register is free or being drained.
    assign pop = head_valid && (!out_valid_reg || decoded.ready);

    always_comb
    begin
        pad_next = pad_reg;
        err_next = err_reg;
        prev_next = prev_reg;
        have_byte = 1'b0;
        byte_val = '0;
        if (pad_reg)
        begin
            if (!(head.kind == KIND_PAD && pos_reg == 2'd3))
            begin
                err_next = 1'b1;
            end
        end
        else if (head.kind == KIND_PAD)
        begin
            if (pos_reg[1])
            begin
                pad_next = 1'b1;
            end
            else
            begin
                err_next = 1'b1;
            end
        end
        else if (head.kind == KIND_BAD)
        begin
            err_next = 1'b1;
        end
        else
        begin
            case (pos_reg)
                2'd1:    byte_val = {prev_reg, head.sextet[5:4]};
                2'd2:    byte_val = {prev_reg[3:0], head.sextet[5:2]};
                2'd3:    byte_val = {prev_reg[1:0], head.sextet};
                default: byte_val = '0;
            endcase
            have_byte = (pos_reg != 2'd0);
            prev_next = head.sextet;
        end
        if (head.fin)
        begin
            // Lone character in the final group, or padding cut short.
            if (pos_reg == 2'd0 || (pad_next && pos_reg != 2'd3))
            begin
                err_next = 1'b1;
            end
        end
        if (err_next)
        begin
            have_byte = 1'b0;
            byte_val = '0;
        end
        pos_next = pos_reg + 1'b1;
        emit = head.fin || have_byte;
    end

    assign load = pop && emit;
    assign out_valid_next = load ? 1'b1 : (decoded.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            prev_reg <= '0;
            pad_reg <= 1'b0;
            err_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                if (head.fin)
                begin
                    pos_reg <= '0;
                    prev_reg <= '0;
                    pad_reg <= 1'b0;
                    err_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_next;
                    prev_reg <= prev_next;
                    pad_reg <= pad_next;
                    err_reg <= err_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_val;
            out_bvalid_reg <= have_byte;
            out_eot_reg <= head.fin;
            out_failed_reg <= head.fin && err_next;
        end
    end

    assign decoded.valid = out_valid_reg;
    assign decoded.data_byte = out_byte_reg;
    assign decoded.byte_valid = out_bvalid_reg;
    assign decoded.end_of_text = out_eot_reg;
    assign decoded.failed = out_failed_reg;

`ifndef NO_ASSERTIONS
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.fin) |=> (pos_reg == 2'd0 && !err_reg && !pad_reg))
        else $error("stream state not cleared after final character");
    a_no_byte_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid |-> !(decoded.byte_valid && decoded.failed))
        else $error("byte released on a failed text");
    a_result_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid |-> (decoded.byte_valid || decoded.end_of_text))
        else $error("empty result released");
`endif

endmodule

/* sv/base64_decoder_checked.sv */
`timescale 1ns / 1ps

// Streaming base64 decoder with validity checking.
//
// text: one character per request (symbol, final_symbol on the last one).
// decoded: one request per completed byte, and always one on the final
//   character carrying end_of_text and the failed verdict.
// cfg: writes alphabet_mode (0 unset, 1 standard, 2 mixed URL-safe); always
//   ready; write only while no text is in flight.
// Throughput: one character per cycle while decoded is not stalled, held by the
//   combinational sextet lookup in the front end and bit splice in the back end.
// Path: an accepted character is first written into the queue, then its result
//   is loaded into the output register once the output is free.
// Reset: mode returns to standard, stream state, queue and output clear.
// Stall: while decoded is stalled the result register holds and the two-entry
//   queue keeps taking characters; text.ready drops once the queue is full.
module base64_decoder_checked (
    input  logic       clk,
    input  logic       rst_n,
    b64d_cfg_if.sink   cfg,
    b64d_text_if.sink  text,
    b64d_byte_if.source decoded
);
    import b64d_pkg::*;

    logic         push;
    queue_entry_t push_entry;
    logic         queue_not_full;
    logic         queue_not_empty;
    logic         pop;
    queue_entry_t head;

    // Front: hold the mode register, classify each character as it arrives.
    b64d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .text        (text),
        .push        (push),
        .push_entry  (push_entry),
        .queue_ready (queue_not_full)
    );

    // Short queue between the two halves so each can stall on its own.
    b64d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .not_full   (queue_not_full),
        .not_empty  (queue_not_empty),
        .pop        (pop),
        .head       (head)
    );

    // Back: group tracking, byte splice, error verdict and result register.
    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (queue_not_empty),
        .head       (head),
        .pop        (pop),
        .decoded    (decoded)
    );

endmodule
